@@ design/hgcd_pkg.sv @@
// Shared constants, types and the arctangent table for the haversine distance pipeline.
package hgcd_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 31;
    localparam int STEP_W       = 6;
    localparam int SQRT_STEP_W  = 5;
    localparam int LANES        = 4;

    localparam int AW       = 34;
    localparam int XW       = 34;
    localparam int ZW       = 36;
    localparam int SQW      = 62;
    localparam int RADIUS_W = 23;
    localparam int DIST_W   = 33;
    localparam int PW       = RADIUS_W + ZW + 1;

    localparam int PREP_LAT  = 7;
    localparam int POST_LAT  = 3;
    localparam int FINAL_LAT = 3;
    localparam int PIPE_LAT  = PREP_LAT + CORDIC_STEPS + POST_LAT + SQRT_STEPS
                               + CORDIC_STEPS + FINAL_LAT;

    localparam logic signed [AW-1:0] TURN_UNITS      = 34'sd3600000000;
    localparam logic signed [AW-1:0] HALF_TURN_UNITS = 34'sd1800000000;
    localparam logic [30:0]          HALF_TURN_U     = 31'd1800000000;
    localparam logic [30:0]          QUARTER_TURN_U  = 31'd900000000;
    localparam logic [31:0]          DEG_TO_RAD_K    = 32'd4024455254;
    localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic [30:0]          ONE_Q30         = 31'd1073741824;
    localparam logic [RADIUS_W-1:0]  RADIUS_RESET    = 23'd6371000;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
    } t_cordic;

    typedef struct packed {
        logic [SQW-1:0] v;
        logic [SQW-1:0] r;
    } t_sqrt;

    // atan(2^-i) in Q32 radians
    function automatic logic signed [ZW-1:0] arctan_q32(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            6'd0:    a = 36'sd3373259426;
            6'd1:    a = 36'sd1991351318;
            6'd2:    a = 36'sd1052175346;
            6'd3:    a = 36'sd534100635;
            6'd4:    a = 36'sd268086748;
            6'd5:    a = 36'sd134174063;
            6'd6:    a = 36'sd67103403;
            6'd7:    a = 36'sd33553749;
            6'd8:    a = 36'sd16777131;
            6'd9:    a = 36'sd8388597;
            6'd10:   a = 36'sd4194303;
            default: a = (i <= 6'd32) ? $signed(ZW'(64'd1 << (6'd32 - i))) : '0;
        endcase
        return a;
    endfunction

endpackage

@@ design/hgcd_prep.sv @@
// Angle preparation: differences, modulo-turn reduction, folding and degree-to-radian scaling.
module hgcd_prep (
    input  logic                              i_clk,
    input  logic                              i_ce,
    input  logic signed [30:0]                i_first_lat,
    input  logic signed [31:0]                i_first_lon,
    input  logic signed [30:0]                i_second_lat,
    input  logic signed [31:0]                i_second_lon,
    output logic signed [hgcd_pkg::ZW-1:0]    o_z [hgcd_pkg::LANES],
    output logic [hgcd_pkg::LANES-1:0]        o_neg
);
    import hgcd_pkg::*;

    // lanes: dlat, dlon, first lat, second lat
    logic signed [AW-1:0] r_s1 [LANES];
    logic signed [AW-1:0] r_s2 [LANES];
    logic signed [AW-1:0] r_s3 [LANES];
    logic [30:0]          r_s4 [LANES];
    logic [30:0]          r_s5 [LANES];
    logic [62:0]          r_s6 [LANES];
    logic signed [ZW-1:0] r_s7 [LANES];
    logic signed [AW-1:0] n_s1 [LANES];
    logic signed [AW-1:0] n_s2 [LANES];
    logic signed [AW-1:0] n_s3 [LANES];
    logic [30:0]          n_s4 [LANES];
    logic [30:0]          n_s5 [LANES];
    logic [62:0]          n_s6 [LANES];
    logic signed [ZW-1:0] n_s7 [LANES];
    logic [LANES-1:0]     r_neg5, r_neg6, r_neg7, n_neg5;

    always_comb begin
        n_s1[0] = AW'(i_second_lat) - AW'(i_first_lat);
        n_s1[1] = AW'(i_second_lon) - AW'(i_first_lon);
        n_s1[2] = AW'(i_first_lat);
        n_s1[3] = AW'(i_second_lat);
        for (int k = 0; k < LANES; k++) begin
            n_s2[k] = r_s1[k][AW-1] ? r_s1[k] + TURN_UNITS : r_s1[k];
            if (r_s2[k][AW-1]) begin
                n_s3[k] = r_s2[k] + TURN_UNITS;
            end else if (r_s2[k] >= TURN_UNITS) begin
                n_s3[k] = r_s2[k] - TURN_UNITS;
            end else begin
                n_s3[k] = r_s2[k];
            end
            n_s4[k] = (r_s3[k] > HALF_TURN_UNITS) ? 31'(TURN_UNITS - r_s3[k]) : 31'(r_s3[k]);
            if (k >= 2 && r_s4[k] > QUARTER_TURN_U) begin
                n_neg5[k] = 1'b1;
                n_s5[k]   = HALF_TURN_U - r_s4[k];
            end else begin
                n_neg5[k] = 1'b0;
                n_s5[k]   = r_s4[k];
            end
            n_s6[k] = 63'(r_s5[k]) * 63'(DEG_TO_RAD_K);
            if (k < 2) begin
                n_s7[k] = $signed(ZW'((r_s6[k] + (63'd1 << 29)) >> 30));
            end else begin
                n_s7[k] = $signed(ZW'((r_s6[k] + (63'd1 << 28)) >> 29));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s1   <= n_s1;
            r_s2   <= n_s2;
            r_s3   <= n_s3;
            r_s4   <= n_s4;
            r_s5   <= n_s5;
            r_s6   <= n_s6;
            r_s7   <= n_s7;
            r_neg5 <= n_neg5;
            r_neg6 <= r_neg5;
            r_neg7 <= r_neg6;
        end
    end

    assign o_z   = r_s7;
    assign o_neg = r_neg7;

endmodule

@@ design/hgcd_cordic_cell.sv @@
// One CORDIC micro-rotation stage, rotation or vectoring mode.
module hgcd_cordic_cell (
    input  logic                             i_clk,
    input  logic                             i_ce,
    input  logic [hgcd_pkg::STEP_W-1:0]      i_step,
    input  logic                             i_vector,
    input  hgcd_pkg::t_cordic                i_d,
    output hgcd_pkg::t_cordic                o_d
);
    import hgcd_pkg::*;

    logic signed [XW-1:0] x, y, dx, dy;
    logic signed [ZW-1:0] z, at;
    logic                 up;
    t_cordic              r_d, n_d;

    always_comb begin
        x  = i_d.x;
        y  = i_d.y;
        z  = i_d.z;
        dx = y >>> i_step;
        dy = x >>> i_step;
        at = arctan_q32(i_step);
        up = i_vector ? y[XW-1] : !z[ZW-1];
        n_d.neg = i_d.neg;
        if (up) begin
            n_d.x = x - dx;
            n_d.y = y + dy;
            n_d.z = z - at;
        end else begin
            n_d.x = x + dx;
            n_d.y = y - dy;
            n_d.z = z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

@@ design/hgcd_sqrt_cell.sv @@
// One bit-pair stage of the restoring integer square root.
module hgcd_sqrt_cell (
    input  logic                              i_clk,
    input  logic                              i_ce,
    input  logic [hgcd_pkg::SQRT_STEP_W-1:0]  i_step,
    input  hgcd_pkg::t_sqrt                   i_d,
    output hgcd_pkg::t_sqrt                   o_d
);
    import hgcd_pkg::*;

    logic [6:0]     pos;
    logic [SQW-1:0] bitv, sum;
    t_sqrt          r_d, n_d;

    always_comb begin
        pos  = 7'd60 - {1'b0, i_step, 1'b0};
        bitv = SQW'(1) << pos;
        sum  = i_d.r + bitv;
        if (i_d.v >= sum) begin
            n_d.v = i_d.v - sum;
            n_d.r = (i_d.r >> 1) + bitv;
        end else begin
            n_d.v = i_d.v;
            n_d.r = i_d.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

@@ design/haversine_great_circle_distance.sv @@
// Top level: haversine great-circle distance pipeline with output register and skid stage.
// Fully pipelined: one coordinate pair enters per cycle while o_in_ready is high and each
// gives one distance (meters times 256) through two CORDIC cell rows and the 31-stage
// square-root row. A stalled output holds one result in the output register and one in
// a skid stage; the input stops only when both are full. The user must write the radius
// register via i_cfg_we / i_cfg_wdata only while the pipeline is empty, which goes unchecked.
module haversine_great_circle_distance (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [30:0]                 i_first_lat,
    input  logic signed [31:0]                 i_first_lon,
    input  logic signed [30:0]                 i_second_lat,
    input  logic signed [31:0]                 i_second_lon,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [hgcd_pkg::DIST_W-1:0]        o_distance_q8,
    input  logic                               i_cfg_we,
    input  logic [hgcd_pkg::RADIUS_W-1:0]      i_cfg_wdata
);
    import hgcd_pkg::*;

    logic                  ce;
    logic                  in_accept;
    logic [PIPE_LAT-1:0]   r_vld;
    logic [RADIUS_W-1:0]   r_radius;

    logic signed [ZW-1:0]  prep_z [LANES];
    logic [LANES-1:0]      prep_neg;

    t_cordic               w_rot [LANES][CORDIC_STEPS+1];
    t_sqrt                 w_sqa [SQRT_STEPS+1];
    t_sqrt                 w_sqb [SQRT_STEPS+1];
    t_cordic               w_vec [CORDIC_STEPS+1];

    logic signed [XW-1:0]   s_lat, s_lon, c_first, c_second, cc;
    logic signed [2*XW-1:0] p_slat, p_slon, p_cc, p_tmp;
    logic signed [XW-1:0]   r_slat, r_slon, r_slat2;
    logic signed [2*XW-1:0] r_ccp, r_tmp;
    logic signed [XW:0]     a_sum;
    logic [30:0]            n_ha, r_ha, r_hb;

    logic signed [ZW-1:0]   z_fin;
    logic [ZW:0]            n_central, r_central;
    logic [PW-1:0]          n_prod, r_prod;
    logic [DIST_W-1:0]      r_dist;

    logic                   out_free;
    logic                   r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;
    logic [DIST_W-1:0]      r_out_dist, n_out_dist, r_skid_dist, n_skid_dist;

    assign ce         = !r_skid_valid;
    assign o_in_ready = ce;
    assign in_accept  = i_in_valid && ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], in_accept};
        end
    end

    hgcd_prep u_prep (
        .i_clk        (i_clk),
        .i_ce         (ce),
        .i_first_lat  (i_first_lat),
        .i_first_lon  (i_first_lon),
        .i_second_lat (i_second_lat),
        .i_second_lon (i_second_lon),
        .o_z          (prep_z),
        .o_neg        (prep_neg)
    );

    // sine of half differences (lanes 0,1), latitude cosines (lanes 2,3)
    for (genvar k = 0; k < LANES; k++) begin : g_rot_lane
        assign w_rot[k][0] = '{x: CORDIC_GAIN_Q30, y: '0, z: prep_z[k], neg: prep_neg[k]};
        for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_rot_cell
            hgcd_cordic_cell u_cell (
                .i_clk    (i_clk),
                .i_ce     (ce),
                .i_step   (STEP_W'(s)),
                .i_vector (1'b0),
                .i_d      (w_rot[k][s]),
                .o_d      (w_rot[k][s+1])
            );
        end
    end

    always_comb begin
        s_lat    = w_rot[0][CORDIC_STEPS].y;
        s_lon    = w_rot[1][CORDIC_STEPS].y;
        c_first  = w_rot[2][CORDIC_STEPS].neg ? -w_rot[2][CORDIC_STEPS].x
                                              : w_rot[2][CORDIC_STEPS].x;
        c_second = w_rot[3][CORDIC_STEPS].neg ? -w_rot[3][CORDIC_STEPS].x
                                              : w_rot[3][CORDIC_STEPS].x;
        p_slat   = s_lat * s_lat;
        p_slon   = s_lon * s_lon;
        p_cc     = c_first * c_second;
        cc       = XW'(r_ccp >>> 30);
        p_tmp    = cc * r_slon;
        a_sum    = (XW+1)'(r_slat2) + (XW+1)'(XW'(r_tmp >>> 30));
        if (a_sum[XW]) begin
            n_ha = '0;
        end else if (a_sum > $signed({4'b0, ONE_Q30})) begin
            n_ha = ONE_Q30;
        end else begin
            n_ha = 31'(a_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_slat  <= XW'(p_slat >>> 30);
            r_slon  <= XW'(p_slon >>> 30);
            r_ccp   <= p_cc;
            r_tmp   <= p_tmp;
            r_slat2 <= r_slat;
            r_ha    <= n_ha;
            r_hb    <= ONE_Q30 - n_ha;
        end
    end

    assign w_sqa[0] = '{v: SQW'({r_ha, 30'b0}), r: '0};
    assign w_sqb[0] = '{v: SQW'({r_hb, 30'b0}), r: '0};

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
        hgcd_sqrt_cell u_sqa (
            .i_clk  (i_clk),
            .i_ce   (ce),
            .i_step (SQRT_STEP_W'(s)),
            .i_d    (w_sqa[s]),
            .o_d    (w_sqa[s+1])
        );
        hgcd_sqrt_cell u_sqb (
            .i_clk  (i_clk),
            .i_ce   (ce),
            .i_step (SQRT_STEP_W'(s)),
            .i_d    (w_sqb[s]),
            .o_d    (w_sqb[s+1])
        );
    end

    assign w_vec[0] = '{x: $signed(XW'(w_sqb[SQRT_STEPS].r)),
                        y: $signed(XW'(w_sqa[SQRT_STEPS].r)),
                        z: '0, neg: 1'b0};

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_vec
        hgcd_cordic_cell u_cell (
            .i_clk    (i_clk),
            .i_ce     (ce),
            .i_step   (STEP_W'(s)),
            .i_vector (1'b1),
            .i_d      (w_vec[s]),
            .o_d      (w_vec[s+1])
        );
    end

    always_comb begin
        z_fin     = w_vec[CORDIC_STEPS].z;
        n_central = z_fin[ZW-1] ? {(ZW)'(-z_fin), 1'b0} : {(ZW)'(z_fin), 1'b0};
        n_prod    = PW'(r_radius) * PW'(r_central);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_central <= n_central;
            r_prod    <= n_prod;
            r_dist    <= DIST_W'((r_prod + (PW'(1) << 23)) >> 24);
        end
    end

    always_comb begin
        out_free     = !r_out_valid || i_out_ready;
        n_out_valid  = r_out_valid;
        n_out_dist   = r_out_dist;
        n_skid_valid = r_skid_valid;
        n_skid_dist  = r_skid_dist;
        if (r_skid_valid) begin
            if (i_out_ready) begin
                n_out_dist   = r_skid_dist;
                n_skid_valid = 1'b0;
            end
        end else if (r_vld[PIPE_LAT-1]) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_dist  = r_dist;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_dist  = r_dist;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_dist  <= n_out_dist;
        r_skid_dist <= n_skid_dist;
    end

    assign o_out_valid   = r_out_valid;
    assign o_distance_q8 = r_out_dist;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && r_vld[PIPE_LAT-1] && ce) |=> r_skid_valid)
        else $error("pipeline result lost during output stall");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_ready) |=> (!r_skid_valid && r_out_valid))
        else $error("skid did not drain into output register");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> $stable(r_vld))
        else $error("pipeline advanced while skid was full");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the haversine great-circle distance pipeline.
`timescale 1ns / 1ps

module testbench;
    import hgcd_pkg::*;

    typedef struct {
        logic signed [30:0] lat1;
        logic signed [31:0] lon1;
        logic signed [30:0] lat2;
        logic signed [31:0] lon2;
    } t_points;

    localparam int     STEPS    = CORDIC_STEPS;
    localparam longint TURN     = 64'sd3600000000;
    localparam longint HALF     = 64'sd1800000000;
    localparam longint QUARTER  = 64'sd900000000;
    localparam longint unsigned RAD_K = 64'd4024455254;
    localparam longint GAIN     = 64'sd652032874;
    localparam longint ONE      = 64'sd1073741824;
    localparam int     N_DIRECT = 18;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic signed [30:0]    i_first_lat;
    logic signed [31:0]    i_first_lon;
    logic signed [30:0]    i_second_lat;
    logic signed [31:0]    i_second_lon;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [DIST_W-1:0]     o_distance_q8;
    logic                  i_cfg_we;
    logic [RADIUS_W-1:0]   i_cfg_wdata;

    logic [RADIUS_W-1:0]   radius_m;
    logic [DIST_W-1:0]     distance_q[$];
    int                    error_count;
    bit                    hold_req;
    t_points               directed[N_DIRECT];

    haversine_great_circle_distance dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_first_lat   (i_first_lat),
        .i_first_lon   (i_first_lon),
        .i_second_lat  (i_second_lat),
        .i_second_lon  (i_second_lon),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_distance_q8 (o_distance_q8),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("[haversine_great_circle_distance] ERROR");
        $finish;
    end

    // ---------------- distance predictor ----------------
    function automatic longint atan_step_q32(int i);
        longint head[11] = '{64'sd3373259426, 64'sd1991351318, 64'sd1052175346,
                             64'sd534100635, 64'sd268086748, 64'sd134174063,
                             64'sd67103403, 64'sd33553749, 64'sd16777131,
                             64'sd8388597, 64'sd4194303};
        if (i < 11) return head[i];
        if (i <= 32) return longint'(64'd1 << (32 - i));
        return 0;
    endfunction

    function automatic longint fold_angle(longint d);
        longint r;
        r = d % TURN;
        if (r < 0) r += TURN;
        if (r > HALF) r = TURN - r;
        return r;
    endfunction

    function automatic void cordic_rotate(longint z, output longint c, output longint s);
        longint x, y, dx, dy;
        x = GAIN;
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step_q32(i);
            end else begin
                x += dx; y -= dy; z += atan_step_q32(i);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint cordic_vector_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_step_q32(i);
            end else begin
                x -= dx; y += dy; z -= atan_step_q32(i);
            end
        end
        return z;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint sin_half_sq_q30(longint d);
        longint unsigned u;
        longint z, c, s;
        u = longint'(fold_angle(d));
        z = longint'((u * RAD_K + (64'd1 << 29)) >> 30);
        cordic_rotate(z, c, s);
        return (s * s) >>> 30;
    endfunction

    function automatic longint lat_cosine_q30(longint lat);
        longint unsigned u;
        longint z, c, s;
        bit flip;
        u = longint'(fold_angle(lat));
        flip = 1'b0;
        if (u > QUARTER) begin
            flip = 1'b1;
            u = HALF - u;
        end
        z = longint'((u * RAD_K + (64'd1 << 28)) >> 29);
        cordic_rotate(z, c, s);
        return flip ? -c : c;
    endfunction

    function automatic logic [DIST_W-1:0] predict_distance(t_points p,
                                                           logic [RADIUS_W-1:0] r);
        longint slat, slon, cc, a, ra, rb, z;
        longint unsigned arc, d;
        slat = sin_half_sq_q30(longint'(p.lat2) - longint'(p.lat1));
        slon = sin_half_sq_q30(longint'(p.lon2) - longint'(p.lon1));
        cc   = (lat_cosine_q30(p.lat1) * lat_cosine_q30(p.lat2)) >>> 30;
        a    = slat + ((cc * slon) >>> 30);
        if (a < 0) a = 0;
        if (a > ONE) a = ONE;
        ra = int_sqrt(longint'(a) << 30);
        rb = int_sqrt(longint'(ONE - a) << 30);
        z  = cordic_vector_angle(rb, ra);
        if (z < 0) z = -z;
        arc = longint'(z) * 2;
        d   = (longint'(r) * arc + (64'd1 << 23)) >> 24;
        return d[DIST_W-1:0];
    endfunction

    // ---------------- scoreboard ----------------
    always @(posedge i_clk) begin
        logic [DIST_W-1:0] want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                distance_q = {distance_q,
                              predict_distance('{i_first_lat, i_first_lon,
                                                 i_second_lat, i_second_lon}, radius_m)};
            if (o_out_valid && i_out_ready) begin
                if (distance_q.size() == 0) begin
                    $display("%0t: unexpected distance %0d", $time, o_distance_q8);
                    error_count++;
                end else begin
                    want = distance_q.pop_front();
                    if (want !== o_distance_q8) begin
                        $display("%0t: distance expected %0d actual %0d",
                                 $time, want, o_distance_q8);
                        error_count++;
                    end
                end
            end
        end
    end

    // ---------------- result sink ----------------
    initial begin
        int mode, left, hold;
        bit held;
        i_out_ready = 1'b0;
        mode = 0;
        left = 0;
        hold = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                hold = 400;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(8, 80);
            end
            left--;
            if (hold > 0) begin
                hold--;
                i_out_ready = 1'b0;
            end else begin
                case (mode)
                    0:       i_out_ready = 1'b1;
                    1:       i_out_ready = ($urandom_range(0, 3) != 0);
                    default: i_out_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ---------------- coordinate source ----------------
    int burst_left = 0;

    task automatic send_points(t_points p);
        i_in_valid   = 1'b1;
        i_first_lat  = p.lat1;
        i_first_lon  = p.lon1;
        i_second_lat = p.lat2;
        i_second_lon = p.lon2;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    function automatic logic signed [30:0] rand_lat();
        return 31'(longint'($urandom_range(0, 1800000000)) - QUARTER);
    endfunction

    function automatic logic signed [31:0] rand_lon();
        return 32'(longint'($urandom_range(0, 32'd3600000000)) - HALF);
    endfunction

    function automatic t_points rand_points();
        t_points p;
        int kind;
        kind = $urandom_range(0, 19);
        p = '{rand_lat(), rand_lon(), rand_lat(), rand_lon()};
        if (kind < 3) begin
            p.lat1 = 31'($urandom);
            p.lon1 = $urandom;
            p.lat2 = 31'($urandom);
            p.lon2 = $urandom;
        end else if (kind == 3) begin
            p.lat2 = p.lat1;
            p.lon2 = p.lon1;
        end else if (kind == 4) begin
            p.lat2 = -p.lat1;
            p.lon2 = 32'(longint'(p.lon1) + HALF);
        end else if (kind == 5) begin
            p.lat2 = 31'(longint'(p.lat1) + $urandom_range(0, 2000) - 1000);
            p.lon2 = 32'(longint'(p.lon1) + $urandom_range(0, 2000) - 1000);
        end
        return p;
    endfunction

    task automatic write_radius(logic [RADIUS_W-1:0] r);
        wait (distance_q.size() == 0);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = r;
        radius_m    = r;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        logic [RADIUS_W-1:0] radii[5] = '{23'd6000000, 23'd7000000, 23'h7FFFFF, 23'd0, 23'd0};
        int counts[5] = '{180, 180, 150, 80, 440};
        directed = '{
            '{31'sd0, 32'sd0, 31'sd0, 32'sd0},
            '{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0},
            '{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000},
            '{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000},
            '{31'sd900000000, 32'sd1234567, 31'sd900000000, -32'sd987654321},
            '{31'sd0, 32'sd1799999999, 31'sd0, -32'sd1799999999},
            '{31'sd515007000, -32'sd1278000, 31'sd407128000, -32'sd740060000},
            '{31'sd100, 32'sd100, 31'sd101, 32'sd100},
            '{31'sd0, 32'sd0, 31'sd0, 32'sd1},
            '{31'sh3FFFFFFF, 32'sh7FFFFFFF, 31'sh40000000, 32'sh80000000},
            '{31'sh40000000, 32'sh80000000, 31'sh40000000, 32'sh80000000},
            '{31'sh3FFFFFFF, 32'sh7FFFFFFF, 31'sh3FFFFFFF, 32'sh7FFFFFFF},
            '{31'sd950000000, 32'sd0, 31'sd0, 32'sd0},
            '{31'sd1000000000, 32'sd500000000, -31'sd1000000000, -32'sd500000000},
            '{31'sh2AAAAAAA, 32'sh55555555, 31'sh55555555, 32'shAAAAAAAA},
            '{-31'sd450000000, 32'sd900000000, 31'sd450000000, -32'sd900000000},
            '{31'sd0, 32'sd0, 31'sd1, 32'sd0},
            '{31'sd899999999, 32'sd0, -31'sd899999999, 32'sd1800000000}
        };
        error_count  = 0;
        hold_req     = 1'b0;
        radius_m     = RADIUS_RESET;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_first_lat  = '0;
        i_first_lon  = '0;
        i_second_lat = '0;
        i_second_lon = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k]) send_points(directed[k]);
        i_in_valid = 1'b0;

        radii[4] = 23'($urandom_range(6000000, 7000000));
        for (int ph = 0; ph < 5; ph++) begin
            write_radius(radii[ph]);
            if (ph == 0) hold_req = 1'b1;
            repeat (counts[ph]) send_points(rand_points());
            i_in_valid = 1'b0;
        end

        wait (distance_q.size() == 0);
        repeat (PIPE_LAT + 20) @(posedge i_clk);
        if (error_count == 0 && distance_q.size() == 0)
            $display("[haversine_great_circle_distance] OK");
        else
            $display("[haversine_great_circle_distance] ERROR");
        $finish;
    end

endmodule
